@@ hdl/twen_pkg.sv @@
// Shared types and character constants for the text whitespace/entity normalizer.
// No dependencies; imported by every module of the block.
package twen_pkg;

    localparam int RES_SLOTS = 5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LESS  = 8'h3C;
    localparam logic [7:0] CH_GREAT = 8'h3E;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_T     = 8'h74;

    // Result group released by one input byte.
    typedef struct packed {
        logic                          valid;  // at least one result to send, or a bare end marker
        logic [RES_SLOTS-1:0][7:0]     bytes;  // slot 0 goes out first
        logic [2:0]                    count;  // results in the group, 1..5
        logic                          bare;   // lone end marker, no byte
        logic                          eos;    // group closes the string
    } twen_res_t;

endpackage

@@ hdl/twen_step.sv @@
// Per-byte normalizer step: state registers plus the combinational rules.
// Depends on twen_pkg.
module twen_step
    import twen_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       go_i,
    input  logic [7:0] char_i,
    input  logic       eos_i,
    output twen_res_t  res_o
);

    logic            run_reg, run_next;
    logic [2:0]      held_cnt_reg, held_cnt_next;
    logic [3:0][7:0] held_reg;

    logic [7:0] h1, h2, h3;
    logic       k1, k2, k3, k4, k_zero;
    logic       lt_pref, lt_full, gt_pref, gt_full, amp_pref, amp_full;
    logic       full, pref;
    logic       case_a, case_b, case_c, case_d, plain;
    logic       is_ws, is_amp, run_eff;
    logic       plain_emit, plain_hold;
    logic [7:0] ent_char, plain_char, x_char, tail;
    logic       xv, ampv;
    logic [2:0] a_cnt, cnt;

    always_comb begin
        h1     = held_reg[1];
        h2     = held_reg[2];
        h3     = held_reg[3];
        k_zero = (held_cnt_reg == 3'd0);
        k1     = (held_cnt_reg == 3'd1);
        k2     = (held_cnt_reg == 3'd2);
        k3     = (held_cnt_reg == 3'd3);
        k4     = (held_cnt_reg == 3'd4);

        lt_pref  = (k1 && char_i == CH_L) || (k2 && h1 == CH_L && char_i == CH_T);
        lt_full  = k3 && h1 == CH_L && h2 == CH_T && char_i == CH_SEMI;
        gt_pref  = (k1 && char_i == CH_G) || (k2 && h1 == CH_G && char_i == CH_T);
        gt_full  = k3 && h1 == CH_G && h2 == CH_T && char_i == CH_SEMI;
        amp_pref = (k1 && char_i == CH_A) || (k2 && h1 == CH_A && char_i == CH_M)
                || (k3 && h1 == CH_A && h2 == CH_M && char_i == CH_P);
        amp_full = k4 && h1 == CH_A && h2 == CH_M && h3 == CH_P && char_i == CH_SEMI;

        full = lt_full || gt_full || amp_full;
        pref = lt_pref || gt_pref || amp_pref;

        case_a = !k_zero && full;
        case_b = !k_zero && !full && pref;
        case_c = !k_zero && !full && !pref;
        case_d = k_zero;
        plain  = case_c || case_d;

        is_ws  = (char_i == CH_SPACE) || (char_i == CH_TAB)
              || (char_i == CH_LF) || (char_i == CH_CR);
        is_amp = (char_i == CH_AMP);
        // a flush of held bytes ends any space run
        run_eff = case_c ? 1'b0 : run_reg;

        plain_emit = plain && !is_amp && (!is_ws || !run_eff);
        plain_hold = plain && is_amp;
        plain_char = is_ws ? CH_SPACE : char_i;
        ent_char   = lt_full ? CH_LESS : (gt_full ? CH_GREAT : CH_AMP);

        // results: a_cnt held bytes, then at most one tail byte
        a_cnt = (case_c || (case_b && eos_i)) ? held_cnt_reg : 3'd0;
        xv    = case_a || plain_emit || (case_b && eos_i);
        x_char = case_a ? ent_char : (case_b ? char_i : plain_char);
        ampv  = plain_hold && eos_i;
        tail  = xv ? x_char : CH_AMP;
        cnt   = a_cnt + {2'b00, (xv || ampv)};

        res_o.bytes[0] = (a_cnt > 3'd0) ? held_reg[0] : tail;
        res_o.bytes[1] = (a_cnt > 3'd1) ? held_reg[1] : tail;
        res_o.bytes[2] = (a_cnt > 3'd2) ? held_reg[2] : tail;
        res_o.bytes[3] = (a_cnt > 3'd3) ? held_reg[3] : tail;
        res_o.bytes[4] = tail;
        res_o.bare     = eos_i && (cnt == 3'd0);
        res_o.count    = (cnt == 3'd0) ? 3'd1 : cnt;
        res_o.eos      = eos_i;
        res_o.valid    = (cnt != 3'd0) || eos_i;
    end

    always_comb begin
        run_next      = run_reg;
        held_cnt_next = held_cnt_reg;
        if (go_i) begin
            if (eos_i) begin
                run_next      = 1'b1;
                held_cnt_next = 3'd0;
            end else if (case_a) begin
                run_next      = 1'b0;
                held_cnt_next = 3'd0;
            end else if (case_b) begin
                held_cnt_next = held_cnt_reg + 3'd1;
            end else begin
                run_next      = is_ws ? 1'b1 : (is_amp ? run_eff : 1'b0);
                held_cnt_next = is_amp ? 3'd1 : 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg      <= 1'b1;
            held_cnt_reg <= 3'd0;
        end else begin
            run_reg      <= run_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go_i && case_b) begin
            held_reg[held_cnt_reg[1:0]] <= char_i;
        end else if (go_i && plain_hold) begin
            held_reg[0] <= CH_AMP;
        end
    end

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_cnt_reg <= 3'd4)
        else $error("held count out of range");

    a_held_amp: assert property (@(posedge aclk) disable iff (!aresetn)
        held_cnt_reg != 3'd0 |-> held_reg[0] == CH_AMP)
        else $error("held entity does not start with ampersand");

    a_res_count: assert property (@(posedge aclk) disable iff (!aresetn)
        go_i && res_o.valid |-> res_o.count != 3'd0 && res_o.count <= 3'(RES_SLOTS))
        else $error("result group count out of range");

endmodule

@@ hdl/twen_emit.sv @@
// Result buffer: holds one result group and sends it out one transfer per slot.
// Depends on twen_pkg.
module twen_emit
    import twen_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load_i,
    input  twen_res_t  res_i,
    output logic       can_load_o,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tuser,   // [0] char_valid
    output logic       m_tlast
);

    logic       vld_reg, vld_next;
    logic [2:0] idx_reg, idx_next;
    twen_res_t  res_reg;
    logic       last_slot;

    assign last_slot  = (idx_reg == res_reg.count - 3'd1);
    assign can_load_o = !vld_reg || (m_tready && last_slot);

    always_comb begin
        vld_next = vld_reg;
        idx_next = idx_reg;
        if (vld_reg && m_tready) begin
            if (last_slot) begin
                vld_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (load_i) begin
            vld_next = 1'b1;
            idx_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= 3'd0;
        end else begin
            vld_reg <= vld_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            res_reg <= res_i;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = res_reg.bare ? 8'h00 : res_reg.bytes[idx_reg];
    assign m_tuser  = !res_reg.bare;
    assign m_tlast  = res_reg.eos && last_slot;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg |-> idx_reg < res_reg.count)
        else $error("slot index beyond result count");

    a_load_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i |-> can_load_o)
        else $error("result group loaded over a pending one");

    a_bare_single: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg && res_reg.bare |-> res_reg.count == 3'd1 && res_reg.eos)
        else $error("bare end marker in a multi-result group");

endmodule

@@ hdl/text_whitespace_entity_normalizer.sv @@
// Top level of the text whitespace/entity normalizer.
// Depends on twen_pkg, twen_step and twen_emit.
//
// One text byte enters per transfer on the s_ side (tlast marks the final
// byte of a string); normalized bytes leave on the m_ side. Leading
// whitespace is dropped, each later whitespace run becomes one space, and
// "&lt;", "&gt;", "&amp;" decode to '<', '>', '&'; an unmatched '&' and the
// bytes held behind it go out literally. A byte enters an input register,
// is processed against the string state in one pass, and its result group
// (zero to five results) goes to a result buffer once it can take the group.
// The buffer sends one result per transfer, so the input runs at one byte
// per cycle while each byte releases at most one result and m_tready stays
// high; a group of several results (failed entity replay, end-of-string
// flush) holds the input until the single-slot buffer has sent it all.
// Output stalls on m_tready hold the input for as long as they last.
// The final result of each string carries m_tlast; if the final byte
// releases nothing, a bare marker with m_tuser low is sent instead.
module text_whitespace_entity_normalizer
    import twen_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tuser,   // [0] char_valid
    output logic       m_tlast    // last
);

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_char_reg;
    logic       in_eos_reg;
    logic       can_load;
    logic       go;
    twen_res_t  res;

    // advance the held byte whenever the result buffer can take its group
    assign go       = in_vld_reg && can_load;
    assign s_tready = !in_vld_reg || go;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (go) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    // payload of the input register needs no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    twen_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go_i    (go),
        .char_i  (in_char_reg),
        .eos_i   (in_eos_reg),
        .res_o   (res)
    );

    // drop groups with no results unless they close the string; those reach the buffer as a bare end marker
    twen_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_i     (go && res.valid),
        .res_i      (res),
        .can_load_o (can_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

@@ sim/text_whitespace_entity_normalizer_test.sv @@
// Self-checking testbench for text_whitespace_entity_normalizer.
// Depends on twen_pkg and the RTL; a scoreboard class predicts every result
// from the accepted byte stream and checks the m_ side transfer by transfer.
module text_whitespace_entity_normalizer_test;
    import twen_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 320;
    localparam int SETTLE_CYCLES = 30;

    // One expected transfer on the result side.
    typedef struct packed {
        logic [7:0] ch;        // out_char
        logic       has_char;  // char_valid, travels as m_tuser
        logic       last;      // m_tlast
    } norm_res_t;

    // Outcome of comparing the held bytes plus the new byte with one entity.
    typedef enum logic [1:0] {
        MATCH_NONE,
        MATCH_PREFIX,
        MATCH_FULL
    } match_e;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_e;

    // Entity spellings after the '&', first byte in the low bits.
    localparam logic [31:0] ENT_LT  = {8'h00, CH_SEMI, CH_T, CH_L};
    localparam logic [31:0] ENT_GT  = {8'h00, CH_SEMI, CH_T, CH_G};
    localparam logic [31:0] ENT_AMP = {CH_SEMI, CH_P, CH_M, CH_A};

    // Predicts the normalized stream and holds the transfers still owed.
    class norm_scoreboard;
        bit        space_run;
        int        held_n;
        bit [7:0]  held [4];
        norm_res_t group [$];
        norm_res_t expected_q [$];
        int        errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            space_run = 1'b1;
            held_n    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void emit(bit [7:0] c, bit has_char);
            if (group.size() < RES_SLOTS)
                group.push_back('{c, has_char, 1'b0});
        endfunction

        function bit is_space(bit [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
        endfunction

        function void flush_held();
            for (int i = 0; i < held_n; i++) begin
                emit(held[i], 1'b1);
                space_run = 1'b0;
            end
            held_n = 0;
        endfunction

        function void plain(bit [7:0] c);
            if (is_space(c)) begin
                if (!space_run) emit(CH_SPACE, 1'b1);
                space_run = 1'b1;
            end else if (c == CH_AMP) begin
                held[0] = CH_AMP;
                held_n  = 1;
            end else begin
                emit(c, 1'b1);
                space_run = 1'b0;
            end
        endfunction

        function match_e entity_match(bit [31:0] pat, int len, bit [7:0] c);
            if (held_n == 0 || held_n > len) return MATCH_NONE;
            for (int i = 1; i < held_n; i++)
                if (held[i] != pat[8*(i-1) +: 8]) return MATCH_NONE;
            if (c != pat[8*(held_n-1) +: 8]) return MATCH_NONE;
            return (held_n == len) ? MATCH_FULL : MATCH_PREFIX;
        endfunction

        // Work out the transfers released by one accepted byte.
        function void note_input(bit [7:0] c, bit eos);
            match_e    m_lt, m_gt, m_amp;
            norm_res_t tail;
            group.delete();
            if (held_n > 0) begin
                m_lt  = entity_match(ENT_LT, 3, c);
                m_gt  = entity_match(ENT_GT, 3, c);
                m_amp = entity_match(ENT_AMP, 4, c);
                if (m_lt == MATCH_FULL || m_gt == MATCH_FULL || m_amp == MATCH_FULL) begin
                    emit(m_lt == MATCH_FULL ? CH_LESS :
                         (m_gt == MATCH_FULL ? CH_GREAT : CH_AMP), 1'b1);
                    space_run = 1'b0;
                    held_n    = 0;
                end else if ((m_lt != MATCH_NONE || m_gt != MATCH_NONE ||
                              m_amp != MATCH_NONE) && held_n < 4) begin
                    held[held_n] = c;
                    held_n++;
                end else begin
                    flush_held();
                    plain(c);
                end
            end else begin
                plain(c);
            end
            if (eos) begin
                flush_held();
                if (group.size() == 0) emit(8'h00, 1'b0);
                tail = group.pop_back();
                tail.last = 1'b1;
                group.push_back(tail);
                restart();
            end
            foreach (group[i]) expected_q.push_back(group[i]);
        endfunction

        function void check_result(logic [7:0] data, logic user, logic last);
            norm_res_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected transfer: out_char %h char_valid %b last %b",
                       data, user, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.ch) begin
                $error("out_char mismatch: expected %h, actual %h", want.ch, data);
                errors++;
            end
            if (user !== want.has_char) begin
                $error("char_valid mismatch: expected %b, actual %b", want.has_char, user);
                errors++;
            end
            if (last !== want.last) begin
                $error("last mismatch: expected %b, actual %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] in_char
    logic       s_tlast;    // end_of_string
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_char
    logic       m_tuser;    // [0] char_valid
    logic       m_tlast;    // last

    norm_scoreboard sb;
    logic [7:0]     text_q [$];
    int             items_sent;
    int             burst_left;
    bit             calm;
    longint         cycles;

    text_whitespace_entity_normalizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Abort a hung run.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sample both channels at the falling edge: everything is driven at the
    // rising edge, so the values seen here are the ones the next rising edge
    // takes. Note the input before checking so a same-cycle pass-through
    // would still find its expectation.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // Receiver: hold each stall pattern for a random span, always-ready
    // stretches included.
    initial begin
        rx_mode_e mode;
        int       span;
        int       tick;
        m_tready <= 1'b0;
        tick = 0;
        forever begin
            mode = rx_mode_e'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(posedge aclk);
                tick++;
                case (mode)
                    RX_ALWAYS:   m_tready <= 1'b1;
                    RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_tready <= (tick % 3) != 0;
                endcase
            end
        end
    end

    // Present one byte and hold it until the transfer happens.
    task automatic send_byte(input logic [7:0] c, input logic eos);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Drop valid for a number of cycles between bursts.
    task automatic idle_gap(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Send text_q as one string, tlast on its final byte, in random bursts.
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == text_q.size() - 1);
            burst_left--;
            if (burst_left <= 0) begin
                idle_gap(calm ? 0 : $urandom_range(1, 6));
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Hold the sender off until every owed transfer has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() > 0);
    endtask

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] entity_char();
        case ($urandom_range(0, 7))
            0:       return CH_L;
            1:       return CH_T;
            2:       return CH_G;
            3:       return CH_A;
            4:       return CH_M;
            5:       return CH_P;
            6:       return CH_SEMI;
            default: return CH_AMP;
        endcase
    endfunction

    // Append one token: an entity, a broken entity, a whitespace run,
    // entity-like letters or a raw byte.
    task automatic add_token();
        logic [31:0] pat;
        int          len;
        int          cut;
        int          pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0:       begin pat = ENT_LT;  len = 3; end
            1:       begin pat = ENT_GT;  len = 3; end
            default: begin pat = ENT_AMP; len = 4; end
        endcase
        if (pick < 30) begin
            text_q.push_back(CH_AMP);
            for (int i = 0; i < len; i++) text_q.push_back(pat[8*i +: 8]);
        end else if (pick < 45) begin
            // Stop short, then break the match with a stray byte.
            cut = $urandom_range(0, len - 1);
            text_q.push_back(CH_AMP);
            for (int i = 0; i < cut; i++) text_q.push_back(pat[8*i +: 8]);
            case ($urandom_range(0, 2))
                0:       text_q.push_back(CH_AMP);
                1:       text_q.push_back(entity_char());
                default: text_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end else if (pick < 62) begin
            repeat ($urandom_range(1, 4)) text_q.push_back(space_char());
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(entity_char());
        end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        sb         = new();
        items_sent = 0;
        burst_left = $urandom_range(1, 12);
        calm       = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Leading whitespace, the byte extremes, a collapsed run and a
        // trailing space.
        text_q = '{CH_SPACE, CH_TAB, 8'h00, CH_CR, CH_LF, 8'hFF, CH_SPACE};
        send_text();
        // All three entities back to back.
        text_q = '{CH_AMP, CH_L, CH_T, CH_SEMI, CH_AMP, CH_G, CH_T, CH_SEMI,
                   CH_AMP, CH_A, CH_M, CH_P, CH_SEMI};
        send_text();
        // Four held bytes replayed, then a new '&' left open at end of string.
        text_q = '{CH_AMP, CH_A, CH_M, CH_P, CH_AMP};
        send_text();
        // Final byte releases nothing: bare end marker.
        text_q = '{CH_SPACE};
        send_text();
        drain();

        while (items_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            text_q.delete();
            if ($urandom_range(0, 9) == 0) begin
                // Single-byte strings reach the bare marker and lone '&'.
                text_q.push_back($urandom_range(0, 1) ? space_char() : entity_char());
            end else begin
                repeat ($urandom_range(1, 6)) add_token();
            end
            send_text();
            // Pause mid-run until the output side has caught up.
            if (items_sent >= 180 && items_sent < 180 + 40 && !calm) begin
                drain();
                calm = 1'b1;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
